[rtl/core/flc_pkg.sv]
// Shared constants and types for the full linear convolution unit.
// No dependencies; compiled before every other file of the block.
package flc_pkg;

    // Delay line depth and number of coefficient registers
    localparam int TAPS     = 6;
    localparam int NCOEF    = 6;

    // Field widths
    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 16;
    localparam int TCNT_W   = 3;
    localparam int VALUE_W  = 18;
    localparam int FRAC     = 16;
    localparam int PROD_W   = SAMPLE_W + COEF_W;
    localparam int ACC_W    = PROD_W + $clog2(TAPS + 1);

    // Pointer into the delay line store, and a tap counter that can hold TAPS
    localparam int PTR_W    = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int CNT_W    = $clog2(TAPS + 1);

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_0    = 3'd1;

    // Reset values
    localparam logic [TCNT_W-1:0]        TAP_COUNT_RST = 3'd1;
    localparam logic signed [COEF_W-1:0] COEF_0_RST    = 16'sd256;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SHIFT = 4'b0010,
        S_MAC   = 4'b0100,
        S_OUT   = 4'b1000
    } t_state;

endpackage

[rtl/core/flc_in_if.sv]
// Input channel of the convolution unit: valid/ready plus one sample.
// Depends on flc_pkg.
interface flc_in_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [flc_pkg::SAMPLE_W-1:0]   sample;
    logic                                  end_of_sequence;

    modport source (output valid, output sample, output end_of_sequence, input ready);
    modport sink   (input valid, input sample, input end_of_sequence, output ready);
endinterface

[rtl/core/flc_out_if.sv]
// Output channel of the convolution unit: valid/ready plus one result.
// Depends on flc_pkg.
interface flc_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [flc_pkg::VALUE_W-1:0]    value;
    logic                                  final_res;

    modport source (output valid, output value, output final_res, input ready);
    modport sink   (input valid, input value, input final_res, output ready);
endinterface

[rtl/core/full_linear_convolution_unit.sv]
// Top level of the full linear convolution unit.
// Depends on flc_pkg, flc_in_if, flc_out_if and flc_ram.

// Each accepted sample gives one result; a sample marked end_of_sequence also
// gives n - 1 tail results (n = effective tap count, 1 to TAPS), after which the
// delay line reads as all zeros again. The delay line sits in a small RAM used
// as a circular buffer and one shared multiplier walks the taps, one per cycle.
// A sample passes from acceptance through the shift, n RAM reads, the read,
// multiply and accumulate registers and the output load; each tail result
// repeats these steps. The next sample can be accepted in the cycle after the
// last load, so the unit takes no new sample while one is in work; output
// stalls hold the sequencer in S_OUT. The single multiplier and the single RAM
// read port set the throughput. The output register lets the next sample be
// accepted while a result waits. Configuration is written through a plain
// write port; the user must write it only while the unit is idle (not enforced).
module full_linear_convolution_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [flc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [flc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    flc_in_if.sink                           i_in,
    flc_out_if.source                        o_out
);

    import flc_pkg::*;

    // Configuration registers
    logic [TCNT_W-1:0]        r_tap_count;
    logic signed [COEF_W-1:0] r_coef [NCOEF];

    // Sequencer
    t_state                   r_state;
    logic [PTR_W-1:0]         r_head;
    logic [PTR_W-1:0]         r_rp;
    logic [CNT_W-1:0]         r_k;
    logic [CNT_W-1:0]         r_t;
    logic                     r_last;
    logic                     r_tail;
    logic [SAMPLE_W-1:0]      r_sample;
    logic [TAPS-1:0]          r_valid;

    // MAC pipeline
    logic                     r_p1_vld;
    logic                     r_p1_live;
    logic [CNT_W-1:0]         r_p1_k;
    logic                     r_p2_vld;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;

    // Output register
    logic                     r_ovld;
    logic signed [VALUE_W-1:0] r_oval;
    logic                     r_ofinal;

    logic [CNT_W-1:0]         n_taps;
    logic [PTR_W-1:0]         n_head;
    logic [PTR_W-1:0]         n_rp;
    logic                     ram_we;
    logic [SAMPLE_W-1:0]      ram_rdata;
    logic signed [COEF_W-1:0] coef_sel;
    logic signed [SAMPLE_W-1:0] tap_data;
    logic signed [PROD_W-1:0] mul;
    logic signed [ACC_W-1:0]  acc_bias;
    logic signed [ACC_W-1:0]  acc_rnd;
    logic                     in_acc;
    logic                     out_acc;
    logic                     issue;
    logic                     out_load;
    logic                     more_tail;

    // Effective tap count: zero counts as one, clipped at TAPS
    always_comb begin
        if (r_tap_count == '0) begin
            n_taps = CNT_W'(1);
        end else if (r_tap_count > TCNT_W'(TAPS)) begin
            n_taps = CNT_W'(TAPS);
        end else begin
            n_taps = CNT_W'(r_tap_count);
        end
    end

    // Circular pointer steps
    assign n_head = (r_head == PTR_W'(TAPS - 1)) ? '0 : r_head + 1'b1;
    assign n_rp   = (r_rp == '0) ? PTR_W'(TAPS - 1) : r_rp - 1'b1;

    assign in_acc    = i_in.valid && i_in.ready;
    assign out_acc   = o_out.valid && o_out.ready;
    assign issue     = (r_state == S_MAC) && (r_k < n_taps);
    assign out_load  = (r_state == S_OUT) && (!r_ovld || o_out.ready);
    assign more_tail = r_last && (r_t < n_taps - 1'b1);
    assign ram_we    = (r_state == S_SHIFT) && !r_tail;

    assign i_in.ready      = (r_state == S_IDLE) && i_rst_n;
    assign o_out.valid     = r_ovld;
    assign o_out.value     = r_oval;
    assign o_out.final_res = r_ofinal;

    // Delay line store
    flc_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (TAPS)
    ) u_delay (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (n_head),
        .i_wdata (r_sample),
        .i_raddr (r_rp),
        .o_rdata (ram_rdata)
    );

    // Coefficient for the tap now leaving the RAM; taps without a register use zero
    always_comb begin
        coef_sel = '0;
        for (int j = 0; j < NCOEF; j++) begin
            if (int'(r_p1_k) == j) begin
                coef_sel = r_coef[j];
            end
        end
    end

    // Entries never written since the last clear read as zero
    assign tap_data = r_p1_live ? $signed(ram_rdata) : '0;
    assign mul      = tap_data * coef_sel;

    // Truncation toward zero: bias negative sums before the arithmetic shift
    assign acc_bias = r_acc[ACC_W-1] ? ACC_W'((1 << FRAC) - 1) : '0;
    assign acc_rnd  = r_acc + acc_bias;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_count <= TAP_COUNT_RST;
            for (int j = 0; j < NCOEF; j++) begin
                r_coef[j] <= (j == 0) ? COEF_0_RST : '0;
            end
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_TAP_COUNT) begin
                r_tap_count <= i_cfg_data[TCNT_W-1:0];
            end
            for (int j = 0; j < NCOEF; j++) begin
                if (i_cfg_idx == REG_COEF_0 + CFG_IDX_W'(j)) begin
                    r_coef[j] <= $signed(i_cfg_data[COEF_W-1:0]);
                end
            end
        end
    end

    // Sequencer: shift, walk the taps, load the result, repeat for the tail
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_head   <= '0;
            r_rp     <= '0;
            r_k      <= '0;
            r_t      <= '0;
            r_last   <= 1'b0;
            r_tail   <= 1'b0;
            r_valid  <= '0;
            r_p1_vld <= 1'b0;
            r_p2_vld <= 1'b0;
        end else begin
            r_p1_vld <= issue;
            r_p2_vld <= r_p1_vld;
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_last  <= i_in.end_of_sequence;
                        r_tail  <= 1'b0;
                        r_t     <= '0;
                        r_state <= S_SHIFT;
                    end
                end
                S_SHIFT: begin
                    r_head           <= n_head;
                    r_rp             <= n_head;
                    r_k              <= '0;
                    r_valid[n_head]  <= !r_tail;
                    r_state          <= S_MAC;
                end
                S_MAC: begin
                    if (issue) begin
                        r_rp <= n_rp;
                        r_k  <= r_k + 1'b1;
                    end else if (!r_p1_vld && !r_p2_vld) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_load) begin
                        if (more_tail) begin
                            r_t     <= r_t + 1'b1;
                            r_tail  <= 1'b1;
                            r_state <= S_SHIFT;
                        end else begin
                            if (r_last) begin
                                r_valid <= '0;
                            end
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_sample <= i_in.sample;
        end
        if (issue) begin
            r_p1_k    <= r_k;
            r_p1_live <= r_valid[r_rp];
        end
        if (r_p1_vld) begin
            r_prod <= mul;
        end
        if (r_state == S_SHIFT) begin
            r_acc <= '0;
        end else if (r_p2_vld) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (out_load) begin
            r_ovld <= 1'b1;
        end else if (out_acc) begin
            r_ovld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_oval   <= acc_rnd[FRAC +: VALUE_W];
            r_ofinal <= r_last && !more_tail;
        end
    end

endmodule

[rtl/core/flc_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module flc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 6
) (
    input  logic                                         i_clk,
    input  logic                                         i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                             i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                             o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

[tb/full_linear_convolution_unit_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for full_linear_convolution_unit: directed and random sample
// sequences under varying idle and stall rates, checked against an in-bench predictor.
// Depends on flc_pkg, flc_in_if, flc_out_if and the unit's RTL.
module full_linear_convolution_unit_tb;
    import flc_pkg::*;

    localparam logic [CFG_IDX_W-1:0]       REG_SPARE     = 3'd7;  // no register behind it
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX    = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN    = 16'sh8000;
    localparam int                         SETTLE_CYCLES = 2 * (TAPS + 5) + 4;
    localparam int                         STALL_LIMIT   = 5000;
    localparam int                         MAX_GAP       = 60;

    typedef struct {
        logic signed [VALUE_W-1:0] value;
        logic                      final_res;
    } t_conv_result;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_cfg_we;
    logic [CFG_IDX_W-1:0]    i_cfg_idx;
    logic [CFG_DATA_W-1:0]   i_cfg_data;

    flc_in_if  in_ch ();
    flc_out_if out_ch ();

    full_linear_convolution_unit uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    // Predictor state: sample history (newest first) and register copies
    logic signed [SAMPLE_W-1:0] sample_hist [TAPS];
    logic signed [COEF_W-1:0]   impulse [NCOEF];
    logic [TCNT_W-1:0]          taps_in_use;

    t_conv_result pending_outputs [$];
    t_conv_result got_res;
    t_conv_result want_res;

    int mismatch_count;
    int send_idle_pct;
    int out_stall_pct;
    int quiet_cycles;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Weighted sum over the first n taps, truncated toward zero to an integer
    function automatic logic signed [VALUE_W-1:0] tap_sum(int n);
        longint acc;
        longint q;
        longint c;
        acc = 0;
        for (int k = 0; k < n; k++) begin
            c = (k < NCOEF) ? longint'(impulse[k]) : 0;
            acc += longint'(sample_hist[k]) * c;
        end
        if (acc < 0) q = -((-acc) >>> FRAC);
        else         q = acc >>> FRAC;
        return q[VALUE_W-1:0];
    endfunction

    function automatic void shift_history(logic signed [SAMPLE_W-1:0] s);
        for (int k = TAPS - 1; k > 0; k--) sample_hist[k] = sample_hist[k - 1];
        sample_hist[0] = s;
    endfunction

    // Outputs caused by one accepted sample, tail included when it ends a sequence
    function automatic void convolve_sample(logic signed [SAMPLE_W-1:0] s, logic eos);
        int n;
        t_conv_result r;
        n = int'(taps_in_use);
        if (n == 0) n = 1;
        if (n > TAPS) n = TAPS;
        shift_history(s);
        r.value     = tap_sum(n);
        r.final_res = eos && (n == 1);
        pending_outputs = {pending_outputs, r};
        if (eos) begin
            for (int t = 1; t < n; t++) begin
                shift_history('0);
                r.value     = tap_sum(n);
                r.final_res = (t == n - 1);
                pending_outputs = {pending_outputs, r};
            end
            for (int k = 0; k < TAPS; k++) sample_hist[k] = '0;
        end
    endfunction

    // Register write; the predictor copy follows once the write has landed
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
        if (idx == REG_TAP_COUNT)
            taps_in_use = data[TCNT_W-1:0];
        else if (idx >= REG_COEF_0 && idx < REG_COEF_0 + NCOEF)
            impulse[idx - REG_COEF_0] = data;
    endtask

    task automatic set_all_coefs(input logic [CFG_DATA_W-1:0] data);
        for (int k = 0; k < NCOEF; k++) write_reg(CFG_IDX_W'(REG_COEF_0 + k), data);
    endtask

    // One input transaction; valid is left high so back-to-back samples need no gap
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input logic eos);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid           <= 1'b1;
        in_ch.sample          <= s;
        in_ch.end_of_sequence <= eos;
        do @(posedge i_clk); while (!in_ch.ready);
        convolve_sample(s, eos);
    endtask

    // Hold the sender until every predicted output is out, then let the pipeline settle
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (pending_outputs.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic signed [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(9))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2:       return '0;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    task automatic randomize_config();
        logic [CFG_DATA_W-1:0] c;
        // mostly legal tap counts, sometimes zero or above the delay line depth
        if ($urandom_range(4) == 0)
            write_reg(REG_TAP_COUNT, CFG_DATA_W'($urandom_range(7)));
        else
            write_reg(REG_TAP_COUNT, CFG_DATA_W'($urandom_range(1, TAPS)));
        for (int k = 0; k < NCOEF; k++) begin
            case ($urandom_range(11))
                0:       c = SAMPLE_MAX;
                1:       c = SAMPLE_MIN;
                2:       c = '0;
                default: c = CFG_DATA_W'($urandom);
            endcase
            write_reg(CFG_IDX_W'(REG_COEF_0 + k), c);
        end
        if ($urandom_range(3) == 0) write_reg(REG_SPARE, CFG_DATA_W'($urandom));
    endtask

    // Reset values: single tap, coefficient 0 at 256, a gain of 1/256
    task automatic test_reset_defaults();
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MIN, 1'b0);
        send_sample(-16'sd1, 1'b1);
        wait_idle();
    endtask

    // Full-scale samples against full-scale coefficients of both signs
    task automatic test_extremes();
        write_reg(REG_TAP_COUNT, CFG_DATA_W'(TAPS));
        set_all_coefs(SAMPLE_MIN);
        send_sample(SAMPLE_MIN, 1'b0);
        send_sample(SAMPLE_MIN, 1'b0);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MIN, 1'b1);
        send_sample(SAMPLE_MAX, 1'b1);   // lone sample, whole tail from one input
        wait_idle();
        set_all_coefs(SAMPLE_MAX);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MIN, 1'b1);
        wait_idle();
    endtask

    // Tap count of zero acts as one, above the depth acts as the depth
    task automatic test_tap_count_limits();
        write_reg(REG_TAP_COUNT, CFG_DATA_W'(0));
        send_sample(16'sh1234, 1'b0);
        send_sample(SAMPLE_MAX, 1'b1);
        wait_idle();
        write_reg(REG_TAP_COUNT, CFG_DATA_W'(7));
        write_reg(REG_SPARE, 16'hFFFF);  // unmapped index, must change nothing
        send_sample(16'sh5A5A, 1'b0);
        send_sample(-16'sh2345, 1'b0);
        send_sample(16'sh0101, 1'b1);
        wait_idle();
    endtask

    // Tap count changed between samples of one sequence; history is kept
    task automatic test_taps_change_mid_sequence();
        write_reg(REG_TAP_COUNT, CFG_DATA_W'(3));
        send_sample(16'sh0400, 1'b0);
        send_sample(-16'sh0280, 1'b0);
        send_sample(16'sh7000, 1'b0);
        wait_idle();
        write_reg(REG_TAP_COUNT, CFG_DATA_W'(5));
        for (int k = 0; k < NCOEF; k++)
            write_reg(CFG_IDX_W'(REG_COEF_0 + k), CFG_DATA_W'($urandom));
        send_sample(16'sh0010, 1'b0);
        send_sample(-16'sh4000, 1'b1);
        wait_idle();
    endtask

    // Random sequences in chunks, each chunk under a fresh register setting
    task automatic test_random(input int idle_pct, input int stall_pct, input int count);
        int sent;
        int chunk;
        int len;
        int pause_at;
        bit broken;
        send_idle_pct = idle_pct;
        out_stall_pct = stall_pct;
        pause_at      = count / 2;
        sent          = 0;
        while (sent < count) begin
            wait_idle();
            randomize_config();
            chunk = 0;
            while (chunk < 30 && sent < count) begin
                len    = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 14);
                broken = ($urandom_range(7) == 0);
                for (int i = 0; i < len && sent < count; i++) begin
                    // sender holds off mid-stream until the unit has drained
                    if (sent == pause_at) wait_idle();
                    send_sample(rand_sample(), (i == len - 1) && !broken);
                    sent++;
                    chunk++;
                end
            end
        end
        wait_idle();
    endtask

    // Output side: random back-pressure and in-order check of each transaction
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got_res.value     = out_ch.value;
            got_res.final_res = out_ch.final_res;
            if (pending_outputs.size() == 0) begin
                $display("%0t: unexpected output, value %0d final_res %0b",
                         $time, got_res.value, got_res.final_res);
                mismatch_count++;
            end else begin
                want_res = pending_outputs.pop_front();
                if (got_res.value !== want_res.value) begin
                    $display("%0t: value mismatch, expected %0d, actual %0d",
                             $time, want_res.value, got_res.value);
                    mismatch_count++;
                end
                if (got_res.final_res !== want_res.final_res) begin
                    $display("%0t: final_res mismatch, expected %0b, actual %0b",
                             $time, want_res.final_res, got_res.final_res);
                    mismatch_count++;
                end
            end
        end
        out_ch.ready <= ($urandom_range(99) >= out_stall_pct);
    end

    // Watchdog on cycles with no transaction on either channel
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || i_cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
            $display("FAIL full_linear_convolution_unit");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Test sequence
    initial begin
        send_idle_pct  = 0;
        out_stall_pct  = 0;
        taps_in_use    = TAP_COUNT_RST;
        for (int k = 0; k < NCOEF; k++) impulse[k] = '0;
        impulse[0] = COEF_0_RST;
        for (int k = 0; k < TAPS; k++) sample_hist[k] = '0;

        i_rst_n               <= 1'b0;
        i_cfg_we              <= 1'b0;
        i_cfg_idx             <= '0;
        i_cfg_data            <= '0;
        in_ch.valid           <= 1'b0;
        in_ch.sample          <= '0;
        in_ch.end_of_sequence <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_extremes();
        test_tap_count_limits();
        test_taps_change_mid_sequence();
        test_random(0, 0, 100);
        test_random(80, 0, 100);
        test_random(0, 80, 100);
        test_random(17, 17, 100);

        if (mismatch_count == 0 && pending_outputs.size() == 0)
            $display("PASS full_linear_convolution_unit");
        else
            $display("FAIL full_linear_convolution_unit");
        $finish;
    end

endmodule

[sim.f]
rtl/core/flc_pkg.sv
rtl/core/flc_in_if.sv
rtl/core/flc_out_if.sv
rtl/core/flc_ram.sv
rtl/core/full_linear_convolution_unit.sv
tb/full_linear_convolution_unit_tb.sv
